// ===== rtl/grid_dda_ray_caster_top_defines.svh =====
// Assertion macros shared by the grid ray caster RTL.
`ifndef GRID_DDA_RAY_CASTER_TOP_DEFINES_SVH
`define GRID_DDA_RAY_CASTER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GDRC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GDRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/gdrc_pkg.sv =====
// Widths, register indexes and constants of the grid ray caster.
`timescale 1ns / 1ps
package gdrc_pkg;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 21;
	localparam int POS_W = 21;
	localparam int EXIT_W = 5;
	localparam int ROWIDX_W = 5;
	localparam int ROWBITS_W = 32;
	localparam int DIR_W = 16;
	localparam int COS_W = 15;
	localparam int HEIGHT_W = 11;
	localparam int TEXCOL_W = 5;
	localparam int SHADE_W = 8;
	localparam int CELL_W = 8;
	localparam int DD_W = 28;
	localparam int DIV_W = 31;
	localparam int DIVC_W = 5;
	localparam int DIST_W = 38;
	localparam int HIT_W = 30;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POS_X  = 2'd0,
		REG_POS_Y  = 2'd1,
		REG_EXIT_X = 2'd2,
		REG_EXIT_Y = 2'd3
	} cfg_reg_t;

	localparam logic [POS_W-1:0] POS_RESET = 21'd98304;
	localparam logic [DIV_W-1:0] STEP_NUM = 31'h4000_0000;
	localparam logic [DD_W-1:0] STEP_FAR = 28'h100_0000;
	localparam logic [DIV_W-1:0] WALL_NUM = 31'd12779520;
	localparam logic [DIST_W-1:0] DIST_MIN = 38'd4096;
	localparam logic [HEIGHT_W-1:0] HEIGHT_CAP = 11'd2000;
	localparam logic [8:0] SHADE_DROP_MAX = 9'd190;
	localparam logic [8:0] SHADE_FULL = 9'd256;
	localparam logic [8:0] SHADE_LO = 9'd12;
	localparam logic [8:0] SHADE_HI = 9'd255;
	localparam logic [DIR_W-1:0] NEAR_ZERO = 16'd4;
endpackage

// ===== rtl/grid_dda_ray_caster_top.sv =====
// Grid ray caster: wall bitmap memory, shared divider and DDA walker.
//
//  channel | direction | handshake            | word
//  in      | input     | in_valid / in_stall  | cmd, row_index, row_bits, ray_dx, ray_dy, view_cos
//  out     | output    | out_valid / out_stall| wall_height, is_exit, tex_column, shade
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// A row write goes straight into the wall memory when accepted. A cast runs the bit-serial
// divider for the two step lengths, then for each grid cell visited reads the wall memory and
// tests it, then scales and clamps the distance and runs the divider again for the wall height.
// The row valid bits are cleared by reset, so the block is ready at once.
// One word is worked on at a time; a finished result waits in the output register.
`timescale 1ns / 1ps
`include "grid_dda_ray_caster_top_defines.svh"
module grid_dda_ray_caster_top #(
	parameter int GRID_DIM = 32,
	parameter int MAX_STEPS = 40,
	parameter int TEX_SIZE = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic cmd,
	input  logic [gdrc_pkg::ROWIDX_W-1:0] row_index,
	input  logic [gdrc_pkg::ROWBITS_W-1:0] row_bits,
	input  logic signed [gdrc_pkg::DIR_W-1:0] ray_dx,
	input  logic signed [gdrc_pkg::DIR_W-1:0] ray_dy,
	input  logic [gdrc_pkg::COS_W-1:0] view_cos,
	output logic out_valid,
	input  logic out_stall,
	output logic [gdrc_pkg::HEIGHT_W-1:0] wall_height,
	output logic is_exit,
	output logic [gdrc_pkg::TEXCOL_W-1:0] tex_column,
	output logic [gdrc_pkg::SHADE_W-1:0] shade,
	input  logic cfg_we,
	input  logic [gdrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gdrc_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int IDX_W = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
	localparam int STEP_W = $clog2(MAX_STEPS + 1);
	localparam int TEXM_W = $clog2(TEX_SIZE + 1);
	localparam int CW = gdrc_pkg::CELL_W;
	localparam int DW = gdrc_pkg::DIST_W;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_DIV_X  = 11'b000_0000_0010,
		ST_DIV_Y  = 11'b000_0000_0100,
		ST_INIT   = 11'b000_0000_1000,
		ST_STEP   = 11'b000_0001_0000,
		ST_TEST   = 11'b000_0010_0000,
		ST_DIST   = 11'b000_0100_0000,
		ST_CLAMP  = 11'b000_1000_0000,
		ST_HIT    = 11'b001_0000_0000,
		ST_DIV_H  = 11'b010_0000_0000,
		ST_FINISH = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	logic in_acc;
	logic out_free;

	logic [gdrc_pkg::POS_W-1:0] pos_x_q, pos_y_q;
	logic [gdrc_pkg::EXIT_W-1:0] exit_x_q, exit_y_q;

	logic signed [gdrc_pkg::DIR_W-1:0] dx_q, dy_q;
	logic [gdrc_pkg::DIR_W-1:0] adx_q, ady_q, in_adx, in_ady;
	logic [gdrc_pkg::COS_W-1:0] cos_q;
	logic dx_pos, dy_pos;

	logic [DW-1:0] div_rem_q, div_den_q, div_rem_n;
	logic [gdrc_pkg::DIV_W-1:0] div_num_q, div_quo_q, div_quo_n;
	logic [gdrc_pkg::DIVC_W-1:0] div_cnt_q;
	logic [DW:0] div_trial;
	logic div_take, div_done;

	logic [gdrc_pkg::DD_W-1:0] ddx_q, ddy_q;
	logic [DW-1:0] sdx_q, sdy_q;
	logic [16:0] fx, fy;
	logic [16+gdrc_pkg::DD_W:0] sdx_prod, sdy_prod;
	logic signed [CW-1:0] cx_q, cy_q, cx_n, cy_n, incx, incy;
	logic step_x, side_q, oob_q, oob_n, solid;
	logic [STEP_W-1:0] step_cnt_q;

	logic [GRID_DIM-1:0] wall_mem [GRID_DIM];
	logic [GRID_DIM-1:0] row_vld_q;
	logic [GRID_DIM-1:0] rd_row_q, wr_row;
	logic rd_vld_q, mem_we, mem_re;
	logic [IDX_W-1:0] mem_waddr, mem_raddr, test_col;

	logic [DW-1:0] dist_sel, dist_sh, dist_q;
	logic [DW+gdrc_pkg::COS_W-1:0] dist_prod_q;
	logic [gdrc_pkg::HIT_W-1:0] hit_prod_q, hit_comp;
	logic [gdrc_pkg::HEIGHT_W-1:0] height_q;

	logic [15:0] frac;
	logic [16+TEXM_W-1:0] tex_prod;
	logic [TEXM_W-1:0] tcol, tcol_m;
	logic mirror;
	logic [8:0] drop, shade_base, shade_adj, shade_cl;
	logic [10:0] shade3;

	logic [gdrc_pkg::HEIGHT_W-1:0] wall_height_q;
	logic is_exit_q, out_valid_q;
	logic [gdrc_pkg::TEXCOL_W-1:0] tex_column_q;
	logic [gdrc_pkg::SHADE_W-1:0] shade_q;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign in_adx = ray_dx[gdrc_pkg::DIR_W-1] ? gdrc_pkg::DIR_W'(-ray_dx) : ray_dx;
	assign in_ady = ray_dy[gdrc_pkg::DIR_W-1] ? gdrc_pkg::DIR_W'(-ray_dy) : ray_dy;
	assign dx_pos = !dx_q[gdrc_pkg::DIR_W-1] && (dx_q != '0);
	assign dy_pos = !dy_q[gdrc_pkg::DIR_W-1] && (dy_q != '0);

	assign div_trial = {div_rem_q, div_num_q[gdrc_pkg::DIV_W-1]};
	assign div_take = div_trial >= {1'b0, div_den_q};
	assign div_rem_n = div_take ? DW'(div_trial - {1'b0, div_den_q}) : div_trial[DW-1:0];
	assign div_quo_n = {div_quo_q[gdrc_pkg::DIV_W-2:0], div_take};
	assign div_done = (div_cnt_q == '0);

	assign fx = dx_pos ? (17'h10000 - {1'b0, pos_x_q[15:0]}) : {1'b0, pos_x_q[15:0]};
	assign fy = dy_pos ? (17'h10000 - {1'b0, pos_y_q[15:0]}) : {1'b0, pos_y_q[15:0]};
	assign sdx_prod = fx * ddx_q;
	assign sdy_prod = fy * ddy_q;

	assign step_x = sdx_q < sdy_q;
	assign incx = dx_pos ? CW'(1) : {CW{1'b1}};
	assign incy = dy_pos ? CW'(1) : {CW{1'b1}};
	assign cx_n = step_x ? cx_q + incx : cx_q;
	assign cy_n = step_x ? cy_q : cy_q + incy;
	assign oob_n = (cx_n < 0) || (cx_n >= GRID_DIM) || (cy_n < 0) || (cy_n >= GRID_DIM);

	assign wr_row = GRID_DIM'(row_bits);
	assign mem_we = in_acc && !cmd && (row_index < GRID_DIM);
	assign mem_waddr = IDX_W'(row_index);
	assign mem_re = (state_q == ST_STEP);
	assign mem_raddr = oob_n ? '0 : cy_n[IDX_W-1:0];
	assign test_col = oob_q ? '0 : cx_q[IDX_W-1:0];
	assign solid = oob_q || (rd_vld_q && rd_row_q[test_col]);

	assign dist_sel = side_q ? (sdy_q - DW'(ddy_q)) : (sdx_q - DW'(ddx_q));
	assign dist_sh = DW'(dist_prod_q >> 14);
	assign hit_comp = side_q ? gdrc_pkg::HIT_W'(dx_q) : gdrc_pkg::HIT_W'(dy_q);

	assign frac = 16'((side_q ? pos_x_q[15:0] : pos_y_q[15:0]) + hit_prod_q[29:14]);
	assign tex_prod = frac * TEXM_W'(TEX_SIZE);
	assign tcol = tex_prod[16+TEXM_W-1:16];
	assign mirror = (!side_q && dx_q[gdrc_pkg::DIR_W-1]) || (side_q && dy_pos);
	assign tcol_m = mirror ? (TEXM_W'(TEX_SIZE - 1) - tcol) : tcol;

	assign drop = (dist_q[DW-1:10] > DW'(gdrc_pkg::SHADE_DROP_MAX)) ?
		gdrc_pkg::SHADE_DROP_MAX : dist_q[18:10];
	assign shade_base = gdrc_pkg::SHADE_FULL - drop;
	assign shade3 = {2'b00, shade_base} + {1'b0, shade_base, 1'b0};
	assign shade_adj = side_q ? shade3[10:2] : shade_base;
	assign shade_cl = (shade_adj < gdrc_pkg::SHADE_LO) ? gdrc_pkg::SHADE_LO :
		((shade_adj > gdrc_pkg::SHADE_HI) ? gdrc_pkg::SHADE_HI : shade_adj);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			wall_mem[mem_waddr] <= wr_row;
		end
		if (mem_re) begin
			rd_row_q <= wall_mem[mem_raddr];
			rd_vld_q <= row_vld_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			row_vld_q <= '0;
			pos_x_q <= gdrc_pkg::POS_RESET;
			pos_y_q <= gdrc_pkg::POS_RESET;
			exit_x_q <= '0;
			exit_y_q <= '0;
			step_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					gdrc_pkg::REG_POS_X: pos_x_q <= cfg_data;
					gdrc_pkg::REG_POS_Y: pos_y_q <= cfg_data;
					gdrc_pkg::REG_EXIT_X: exit_x_q <= cfg_data[gdrc_pkg::EXIT_W-1:0];
					gdrc_pkg::REG_EXIT_Y: exit_y_q <= cfg_data[gdrc_pkg::EXIT_W-1:0];
					default: ;
				endcase
			end
			if (mem_we) begin
				row_vld_q[mem_waddr] <= 1'b1;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && cmd) begin
						state_q <= ST_DIV_X;
					end
				end
				ST_DIV_X: begin
					if (div_done) begin
						state_q <= ST_DIV_Y;
					end
				end
				ST_DIV_Y: begin
					if (div_done) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					step_cnt_q <= '0;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					step_cnt_q <= step_cnt_q + STEP_W'(1);
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					if (solid || (step_cnt_q == STEP_W'(MAX_STEPS))) begin
						state_q <= ST_DIST;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_DIST: state_q <= ST_CLAMP;
				ST_CLAMP: state_q <= ST_HIT;
				ST_HIT: state_q <= ST_DIV_H;
				ST_DIV_H: begin
					if (div_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		div_rem_q <= div_rem_n;
		div_quo_q <= div_quo_n;
		div_num_q <= {div_num_q[gdrc_pkg::DIV_W-2:0], 1'b0};
		div_cnt_q <= div_cnt_q - gdrc_pkg::DIVC_W'(1);
		case (state_q)
			ST_IDLE: begin
				if (in_acc && cmd) begin
					dx_q <= ray_dx;
					dy_q <= ray_dy;
					adx_q <= in_adx;
					ady_q <= in_ady;
					cos_q <= view_cos;
					div_rem_q <= '0;
					div_num_q <= gdrc_pkg::STEP_NUM;
					div_den_q <= DW'(in_adx);
					div_cnt_q <= gdrc_pkg::DIVC_W'(gdrc_pkg::DIV_W - 1);
				end
			end
			ST_DIV_X: begin
				if (div_done) begin
					ddx_q <= (adx_q > gdrc_pkg::NEAR_ZERO) ?
						div_quo_n[gdrc_pkg::DD_W-1:0] : gdrc_pkg::STEP_FAR;
					div_rem_q <= '0;
					div_num_q <= gdrc_pkg::STEP_NUM;
					div_den_q <= DW'(ady_q);
					div_cnt_q <= gdrc_pkg::DIVC_W'(gdrc_pkg::DIV_W - 1);
				end
			end
			ST_DIV_Y: begin
				if (div_done) begin
					ddy_q <= (ady_q > gdrc_pkg::NEAR_ZERO) ?
						div_quo_n[gdrc_pkg::DD_W-1:0] : gdrc_pkg::STEP_FAR;
				end
			end
			ST_INIT: begin
				sdx_q <= DW'(sdx_prod >> 16);
				sdy_q <= DW'(sdy_prod >> 16);
				cx_q <= CW'(pos_x_q[gdrc_pkg::POS_W-1:16]);
				cy_q <= CW'(pos_y_q[gdrc_pkg::POS_W-1:16]);
				side_q <= 1'b0;
			end
			ST_STEP: begin
				cx_q <= cx_n;
				cy_q <= cy_n;
				oob_q <= oob_n;
				side_q <= !step_x;
				if (step_x) begin
					sdx_q <= sdx_q + DW'(ddx_q);
				end else begin
					sdy_q <= sdy_q + DW'(ddy_q);
				end
			end
			ST_DIST: begin
				dist_prod_q <= dist_sel * cos_q;
			end
			ST_CLAMP: begin
				dist_q <= (dist_sh < gdrc_pkg::DIST_MIN) ? gdrc_pkg::DIST_MIN : dist_sh;
			end
			ST_HIT: begin
				hit_prod_q <= gdrc_pkg::HIT_W'(dist_q[gdrc_pkg::HIT_W-1:0] * hit_comp);
				div_rem_q <= '0;
				div_num_q <= gdrc_pkg::WALL_NUM;
				div_den_q <= dist_q;
				div_cnt_q <= gdrc_pkg::DIVC_W'(gdrc_pkg::DIV_W - 1);
			end
			ST_DIV_H: begin
				if (div_done) begin
					height_q <= (div_quo_n > gdrc_pkg::DIV_W'(gdrc_pkg::HEIGHT_CAP)) ?
						gdrc_pkg::HEIGHT_CAP : div_quo_n[gdrc_pkg::HEIGHT_W-1:0];
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					wall_height_q <= height_q;
					is_exit_q <= (cx_q == CW'(exit_x_q)) && (cy_q == CW'(exit_y_q));
					tex_column_q <= gdrc_pkg::TEXCOL_W'(tcol_m);
					shade_q <= shade_cl[gdrc_pkg::SHADE_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign wall_height = wall_height_q;
	assign is_exit = is_exit_q;
	assign tex_column = tex_column_q;
	assign shade = shade_q;

	`GDRC_ASSERT_NEXT(a_cast_starts, clk, arst_n, in_valid && !in_stall && cmd, state_q == ST_DIV_X, "accepted cast did not start the divider")
	`GDRC_ASSERT_NEXT(a_row_silent, clk, arst_n, in_valid && !in_stall && !cmd && !out_valid, !out_valid, "row write produced a result")
	`GDRC_ASSERT_NOW(a_step_bound, clk, arst_n, 1'b1, step_cnt_q <= STEP_W'(MAX_STEPS), "DDA step count beyond limit")
	`GDRC_ASSERT_NOW(a_height_cap, clk, arst_n, out_valid, wall_height <= gdrc_pkg::HEIGHT_CAP, "wall height above cap")
endmodule
